@@ hdl/pca_pkg.sv @@
// ----------------------------------------------------------------------------
// pca_pkg: shared constants and types for the page chain allocator
// Field widths, request and status codes and the reset value of the page
// count register.
// ----------------------------------------------------------------------------
package pca_pkg;

    localparam int BYTE_COUNT_W = 23;
    localparam int ADDR_W       = 22;
    localparam int PAGES_W      = 11;
    localparam int CFG_W        = 11;

    typedef logic [BYTE_COUNT_W-1:0] byte_count_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [PAGES_W-1:0]      pages_t;
    typedef logic [CFG_W-1:0]        cfg_t;

    // request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_MEM = 1'b1;

    localparam cfg_t MEM_PAGES_RESET = 11'd1024;

endpackage

@@ hdl/pca_if.sv @@
// ----------------------------------------------------------------------------
// pca_if: request and response channels of the page chain allocator
// Valid/ready channels; an item moves on a clock edge with valid and ready
// both high.
// ----------------------------------------------------------------------------
interface pca_req_if;
    import pca_pkg::*;

    logic        valid;
    logic        ready;
    logic        action;
    byte_count_t byte_count;
    addr_t       start_address;

    modport source (output valid, output action, output byte_count,
                    output start_address, input ready);
    modport sink   (input valid, input action, input byte_count,
                    input start_address, output ready);
endinterface

interface pca_rsp_if;
    import pca_pkg::*;

    logic   valid;
    logic   ready;
    logic   status;
    addr_t  result_address;
    pages_t pages_changed;

    modport source (output valid, output status, output result_address,
                    output pages_changed, input ready);
    modport sink   (input valid, input status, input result_address,
                    input pages_changed, output ready);
endinterface

@@ hdl/page_chain_allocator_core.sv @@
// ----------------------------------------------------------------------------
// page_chain_allocator_core: linked page allocation table
// Allocates chains of the lowest free pages and frees chains by walking
// their links, with the table held in one synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ------------------------------------------
//  req      in   valid/ready    action, byte_count, start_address
//  rsp      out  valid/ready    status, result_address, pages_changed
//  cfg      in   cfg_wr_en      cfg_wr_data (memory_pages)
//
//  Allocate: a counting scan and a linking scan, each reading one table
//  entry per cycle up to the Nth free page; rejected sizes skip both
//  scans. Free: walks the chain from the given page, clearing each entry.
//  After reset the table is cleared with req.ready low.
//  One item is in work at a time; a finished result waits in the output
//  register while the next item is taken, and rsp stalls hold the block
//  only once a second result is ready.
//
module page_chain_allocator_core #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  pca_pkg::cfg_t    cfg_wr_data,
    pca_req_if.sink          req,
    pca_rsp_if.source        rsp
);
    import pca_pkg::*;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int ENT_W  = $clog2(NUM_PAGES + 2);
    localparam int SZ_W   = CNT_W + PAGE_SHIFT;
    localparam int CMP_W  = (SZ_W > BYTE_COUNT_W) ? SZ_W : BYTE_COUNT_W;
    localparam int RND_W  = BYTE_COUNT_W + 1;
    localparam int FB_W   = PAGE_W + PAGE_SHIFT;

    localparam logic [ENT_W-1:0] ENTRY_END  = ENT_W'(NUM_PAGES + 1);
    localparam logic [RND_W-1:0] PAGE_ROUND = RND_W'((1 << PAGE_SHIFT) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_LINK,
        S_END,
        S_WALK,
        S_DONE
    } state_t;

    state_t            state_reg;
    cfg_t              mem_pages_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  need_reg;
    logic [CNT_W-1:0]  scan_addr_reg;
    logic              rd_pend_reg;
    logic [PAGE_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0]  tally_reg;
    logic [PAGE_W-1:0] first_reg;
    logic [PAGE_W-1:0] prev_reg;
    logic [PAGE_W-1:0] walk_page_reg;
    logic              status_reg;

    logic              rsp_valid_reg;
    logic              rsp_status_reg;
    addr_t             rsp_addr_reg;
    pages_t            rsp_pages_reg;

    logic              tbl_ready;
    logic [PAGE_W-1:0] tbl_rd_addr;
    logic [ENT_W-1:0]  tbl_rd_data;
    logic              tbl_wr_en;
    logic [PAGE_W-1:0] tbl_wr_addr;
    logic [ENT_W-1:0]  tbl_wr_data;

    logic              req_fire;
    logic [CNT_W-1:0]  limit_now;
    logic [CMP_W-1:0]  mem_bytes;
    logic              too_big;
    logic [RND_W-1:0]  round_up;
    logic [RND_W-1:0]  need_full;
    logic [ADDR_W-1:0] addr_page;
    logic              page_ok;
    logic              issue;
    logic              hit;
    logic [CNT_W-1:0]  tally_inc;
    logic [PAGE_W-1:0] next_page;
    logic [FB_W-1:0]   first_bytes;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_pages_reg <= MEM_PAGES_RESET;
        end
        else if (cfg_wr_en)
        begin
            mem_pages_reg <= cfg_wr_data;
        end
    end

    // decode the request: managed pages, size check, page count, free page
    always_comb
    begin
        if (32'(mem_pages_reg) > NUM_PAGES)
        begin
            limit_now = CNT_W'(NUM_PAGES);
        end
        else
        begin
            limit_now = CNT_W'(mem_pages_reg);
        end
        mem_bytes = CMP_W'(limit_now) << PAGE_SHIFT;
        too_big   = CMP_W'(req.byte_count) >= mem_bytes;
        round_up  = (RND_W'(req.byte_count) + PAGE_ROUND) >> PAGE_SHIFT;
        need_full = (round_up == '0) ? RND_W'(1) : round_up;
        addr_page = req.start_address >> PAGE_SHIFT;
        page_ok   = 32'(addr_page) < NUM_PAGES;
    end

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && tbl_ready;

    assign issue       = scan_addr_reg < limit_reg;
    assign hit         = rd_pend_reg && (tbl_rd_data == '0);
    assign tally_inc   = tally_reg + 1'b1;
    assign next_page   = PAGE_W'(tbl_rd_data - 1'b1);
    assign first_bytes = {first_reg, {PAGE_SHIFT{1'b0}}};

    // table read address and write command
    always_comb
    begin
        tbl_rd_addr = scan_addr_reg[PAGE_W-1:0];
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = prev_reg;
        tbl_wr_data = '0;
        case (state_reg)
            S_LINK:
            begin
                // link the previous page to this free one
                if (hit && (tally_reg != '0))
                begin
                    tbl_wr_en   = 1'b1;
                    tbl_wr_addr = prev_reg;
                    tbl_wr_data = ENT_W'(rd_idx_reg) + 1'b1;
                end
            end
            S_END:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = prev_reg;
                tbl_wr_data = ENTRY_END;
            end
            S_WALK:
            begin
                tbl_rd_addr = rd_pend_reg ? next_page : walk_page_reg;
                // clear the entry just read
                if (rd_pend_reg && (tbl_rd_data != '0))
                begin
                    tbl_wr_en   = 1'b1;
                    tbl_wr_addr = walk_page_reg;
                    tbl_wr_data = '0;
                end
            end
            default:
            begin
                tbl_wr_en = 1'b0;
            end
        endcase
    end

    pca_table #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_W    (PAGE_W),
        .ENT_W     (ENT_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .ready   (tbl_ready)
    );

    // request sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_pend_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            limit_reg      <= '0;
            need_reg       <= '0;
            scan_addr_reg  <= '0;
            rd_idx_reg     <= '0;
            tally_reg      <= '0;
            first_reg      <= '0;
            prev_reg       <= '0;
            walk_page_reg  <= '0;
            status_reg     <= STATUS_OK;
            rsp_status_reg <= STATUS_OK;
            rsp_addr_reg   <= '0;
            rsp_pages_reg  <= '0;
        end
        else
        begin
            // drop a result once taken
            if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        tally_reg     <= '0;
                        first_reg     <= '0;
                        status_reg    <= STATUS_OK;
                        scan_addr_reg <= '0;
                        rd_pend_reg   <= 1'b0;
                        limit_reg     <= limit_now;
                        need_reg      <= CNT_W'(need_full);
                        walk_page_reg <= PAGE_W'(addr_page);
                        if (req.action == ACT_FREE)
                        begin
                            state_reg <= page_ok ? S_WALK : S_DONE;
                        end
                        else if (too_big)
                        begin
                            status_reg <= STATUS_NO_MEM;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_COUNT;
                        end
                    end
                end

                S_COUNT:
                begin
                    // stream reads and count free entries
                    rd_pend_reg <= issue;
                    rd_idx_reg  <= scan_addr_reg[PAGE_W-1:0];
                    if (issue)
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        tally_reg <= tally_inc;
                    end
                    if (hit && (tally_inc >= need_reg))
                    begin
                        tally_reg     <= '0;
                        scan_addr_reg <= '0;
                        rd_pend_reg   <= 1'b0;
                        state_reg     <= S_LINK;
                    end
                    else if (!rd_pend_reg && !issue)
                    begin
                        tally_reg  <= '0;
                        status_reg <= STATUS_NO_MEM;
                        state_reg  <= S_DONE;
                    end
                end

                S_LINK:
                begin
                    // take the lowest free pages in order
                    rd_pend_reg <= issue;
                    rd_idx_reg  <= scan_addr_reg[PAGE_W-1:0];
                    if (issue)
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        if (tally_reg == '0)
                        begin
                            first_reg <= rd_idx_reg;
                        end
                        prev_reg  <= rd_idx_reg;
                        tally_reg <= tally_inc;
                        if (tally_inc == need_reg)
                        begin
                            rd_pend_reg <= 1'b0;
                            state_reg   <= S_END;
                        end
                    end
                end

                S_END:
                begin
                    state_reg <= S_DONE;
                end

                S_WALK:
                begin
                    // follow the chain, one entry per cycle
                    rd_pend_reg <= 1'b1;
                    if (rd_pend_reg)
                    begin
                        if (tbl_rd_data == '0)
                        begin
                            rd_pend_reg <= 1'b0;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            tally_reg     <= tally_inc;
                            walk_page_reg <= next_page;
                            if (tbl_rd_data >= ENTRY_END)
                            begin
                                rd_pend_reg <= 1'b0;
                                state_reg   <= S_DONE;
                            end
                        end
                    end
                end

                S_DONE:
                begin
                    // hold until the output register is free
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        rsp_addr_reg   <= ADDR_W'(first_bytes);
                        rsp_pages_reg  <= PAGES_W'(tally_reg);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.result_address = rsp_addr_reg;
    assign rsp.pages_changed  = rsp_pages_reg;

    // no item is taken while the table is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        !tbl_ready |-> !req.ready)
        else $error("request accepted during table clear");

    // a finished chain holds exactly the requested page count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_END) |-> (tally_reg == need_reg))
        else $error("allocated page count differs from request");

    // the table is never written while idle or while holding a finished result
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) || (state_reg == S_DONE)) |-> !tbl_wr_en)
        else $error("table write outside a request");

    // a failed allocation reports no pages
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg == STATUS_NO_MEM)) |->
            ((rsp_pages_reg == '0) && (rsp_addr_reg == '0)))
        else $error("failed allocation reports pages");

endmodule

@@ hdl/pca_table.sv @@
// ----------------------------------------------------------------------------
// pca_table: page chain table memory
// One entry per page, one write and one registered read per cycle. After
// reset a sweep writes every entry to free before ready rises.
// ----------------------------------------------------------------------------
module pca_table #(
    parameter int NUM_PAGES = 1024,
    parameter int PAGE_W    = $clog2(NUM_PAGES),
    parameter int ENT_W     = $clog2(NUM_PAGES + 2)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PAGE_W-1:0] rd_addr,
    output logic [ENT_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [PAGE_W-1:0] wr_addr,
    input  logic [ENT_W-1:0]  wr_data,
    output logic              ready
);

    logic [ENT_W-1:0]  table_mem [NUM_PAGES];
    logic [ENT_W-1:0]  rd_data_reg;
    logic              clr_active_reg;
    logic [PAGE_W-1:0] clr_addr_reg;

    logic              mem_we;
    logic [PAGE_W-1:0] mem_wa;
    logic [ENT_W-1:0]  mem_wd;

    // sweep owns the write port until every entry is cleared
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    // advance the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == PAGE_W'(NUM_PAGES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // memory array with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_active_reg;

endmodule

@@ dv/tb_page_chain_allocator_core.sv @@
// ----------------------------------------------------------------------------
// tb_page_chain_allocator_core: self-checking bench for the page allocator
// Drives allocate and free requests through the valid/ready channels, keeps
// a local copy of the page link table to predict every response, and
// compares each response field by field. Covers size rounding, full and
// empty memory, page count register extremes and chain walks from any page.
// ----------------------------------------------------------------------------
module tb_page_chain_allocator_core;
    import pca_pkg::*;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam int CLK_PERIOD = 8;
    localparam int LINK_END   = NUM_PAGES + 1;

    typedef struct packed {
        logic   status;
        addr_t  addr;
        pages_t pages;
    } rsp_item_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_wr_en;
    cfg_t   cfg_wr_data;

    pca_req_if req_ch ();
    pca_rsp_if rsp_ch ();

    page_chain_allocator_core #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // local copy of the page link table: 0 free, n+1 next page n, LINK_END last
    int unsigned link_table [NUM_PAGES];
    cfg_t        mem_pages_model;
    rsp_item_t   due_results[$];
    int unsigned chain_heads[$];

    bit req_idling;
    bit rsp_idling;
    int mismatches;
    int responses_checked;
    int allocs_ok;
    int allocs_failed;
    int frees_done;
    int pages_released;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard limit on run length
    initial
    begin
        #(CLK_PERIOD * 6000000);
        $display("timeout with %0d responses still due", due_results.size());
        $display("tb_page_chain_allocator_core: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic rsp_item_t model_allocate(input byte_count_t cnt);
        rsp_item_t   r;
        int unsigned limit;
        int unsigned need;
        int unsigned free_pages;
        int unsigned done;
        int unsigned first;
        int unsigned prev;
        r.status = STATUS_NO_MEM;
        r.addr   = '0;
        r.pages  = '0;
        limit = (int'(mem_pages_model) > NUM_PAGES) ? NUM_PAGES : int'(mem_pages_model);
        need  = (int'(cnt) + PAGE_BYTES - 1) >> PAGE_SHIFT;
        if (need == 0)
            need = 1;
        // reject sizes that reach the memory size
        if (int'(cnt) >= (limit << PAGE_SHIFT))
        begin
            allocs_failed++;
            return r;
        end
        free_pages = 0;
        for (int i = 0; i < limit; i++)
            if (link_table[i] == 0)
                free_pages++;
        if (free_pages < need)
        begin
            allocs_failed++;
            return r;
        end
        // link the lowest free pages in ascending order
        done  = 0;
        first = 0;
        prev  = 0;
        for (int i = 0; i < limit && done < need; i++)
        begin
            if (link_table[i] != 0)
                continue;
            if (done == 0)
                first = i;
            else
                link_table[prev] = i + 1;
            link_table[i] = LINK_END;
            prev = i;
            done++;
        end
        r.status = STATUS_OK;
        r.addr   = addr_t'(first << PAGE_SHIFT);
        r.pages  = pages_t'(done);
        chain_heads.push_back(first);
        allocs_ok++;
        return r;
    endfunction

    function automatic rsp_item_t model_free(input addr_t addr);
        rsp_item_t   r;
        int unsigned page;
        int unsigned entry;
        int unsigned freed;
        r.status = STATUS_OK;
        r.addr   = '0;
        page  = int'(addr) >> PAGE_SHIFT;
        freed = 0;
        frees_done++;
        // walk the chain and clear every entry passed
        if (page < NUM_PAGES)
        begin
            for (int steps = 0; steps < NUM_PAGES; steps++)
            begin
                entry = link_table[page];
                if (entry == 0)
                    break;
                link_table[page] = 0;
                freed++;
                if (entry >= LINK_END)
                    break;
                page = entry - 1;
            end
        end
        r.pages = pages_t'(freed);
        pages_released += freed;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // response side: ready bursts and checking
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rsp_idling && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin : check_rsp
        rsp_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_results.size() == 0)
                note_mismatch($sformatf("unexpected response status %0b addr %h pages %0d",
                              rsp_ch.status, rsp_ch.result_address, rsp_ch.pages_changed));
            else
            begin
                want = due_results.pop_front();
                responses_checked++;
                if (rsp_ch.status !== want.status)
                    note_mismatch($sformatf("status exp %0b got %0b",
                                  want.status, rsp_ch.status));
                if (rsp_ch.result_address !== want.addr)
                    note_mismatch($sformatf("result_address exp %h got %h",
                                  want.addr, rsp_ch.result_address));
                if (rsp_ch.pages_changed !== want.pages)
                    note_mismatch($sformatf("pages_changed exp %0d got %0d",
                                  want.pages, rsp_ch.pages_changed));
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // send one item, predict its response once it is taken
    task automatic send_request(input logic act, input byte_count_t cnt, input addr_t addr);
        if (req_idling && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.byte_count    <= cnt;
        req_ch.start_address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (act == ACT_ALLOC)
            due_results.push_back(model_allocate(cnt));
        else
            due_results.push_back(model_free(addr));
    endtask

    task automatic send_alloc(input int unsigned cnt);
        send_request(ACT_ALLOC, byte_count_t'(cnt), addr_t'($urandom));
    endtask

    task automatic send_free(input int unsigned addr);
        send_request(ACT_FREE, byte_count_t'($urandom), addr_t'(addr));
    endtask

    // hold requests until every response is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_memory_pages(input cfg_t pages);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pages;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mem_pages_model = pages;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // rounding, chain walks and a full memory at the reset page count
    task automatic test_sizes_and_chains();
        send_alloc(0);                              // zero bytes: one page
        send_alloc(1);
        send_alloc(PAGE_BYTES);
        send_alloc(PAGE_BYTES + 1);                 // two pages
        send_alloc(NUM_PAGES * PAGE_BYTES);         // reaches memory size
        send_alloc(NUM_PAGES * PAGE_BYTES - 1);     // too few free pages
        send_free((4 << PAGE_SHIFT) | 12'hFFF);     // last page of a chain, low bits set
        send_free((3 << PAGE_SHIFT) | 12'h001);     // head of the now short chain
        send_free(1000 << PAGE_SHIFT);              // page already free
        send_free(0);
        send_free((1 << PAGE_SHIFT) | 12'h800);
        send_free(22'h3FFFFF);                      // last page, free
        send_free(2 << PAGE_SHIFT);
        send_alloc(NUM_PAGES * PAGE_BYTES - 1);     // whole memory
        send_alloc(0);                              // nothing left
        send_free(0);                               // release all pages
    endtask

    // page count register at its extremes
    task automatic test_page_count_limits();
        write_memory_pages(cfg_t'(0));
        send_alloc(0);                              // every allocate fails
        send_free(5 << PAGE_SHIFT);
        write_memory_pages(cfg_t'(1));
        send_alloc(0);
        send_alloc(0);
        send_alloc(PAGE_BYTES);
        send_free(0);
        write_memory_pages(cfg_t'(2047));           // saturates at the table size
        send_alloc(NUM_PAGES * PAGE_BYTES - 1);
        send_free(0);
    endtask

    task automatic send_random_request(input int unsigned limit);
        int unsigned sel;
        int unsigned idx;
        int unsigned page;
        sel = $urandom_range(0, 99);
        if (sel < 52)
        begin
            // allocate: mostly small, some at or next to page multiples, few large
            sel = $urandom_range(0, 99);
            if (sel < 60)
                send_alloc($urandom_range(0, 6 * PAGE_BYTES));
            else if (sel < 82)
                send_alloc(($urandom_range(1, 8) << PAGE_SHIFT) + $urandom_range(0, 2) - 1);
            else if (sel < 95)
                send_alloc($urandom_range(0, (limit + 1) << PAGE_SHIFT));
            else
                send_alloc($urandom_range(0, 23'h7FFFFF));
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50 && chain_heads.size() != 0)
            begin
                // free a chain from its head
                idx  = $urandom_range(0, chain_heads.size() - 1);
                page = chain_heads[idx];
                chain_heads.delete(idx);
                send_free((page << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1));
            end
            else if (sel < 75)
            begin
                // free from a page in use, often mid-chain
                page = $urandom_range(0, NUM_PAGES - 1);
                for (int k = 0; k < 16 && link_table[page] == 0; k++)
                    page = $urandom_range(0, NUM_PAGES - 1);
                send_free((page << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1));
            end
            else
                send_free($urandom_range(0, 22'h3FFFFF));
        end
    endtask

    // random traffic over several page counts
    task automatic test_random_traffic();
        cfg_t settings [6];
        int   per_phase;
        settings  = '{cfg_t'(64), cfg_t'(1024), cfg_t'(13), cfg_t'(300),
                      cfg_t'(2047), cfg_t'(1024)};
        per_phase = 90;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_memory_pages(settings[ph]);
            // no idling in the middle stretch and in the closing phase
            req_idling = (ph != 3 && ph != 5);
            rsp_idling = (ph != 3 && ph != 5);
            for (int n = 0; n < per_phase; n++)
                send_random_request((int'(settings[ph]) > NUM_PAGES) ?
                                    NUM_PAGES : int'(settings[ph]));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= MEM_PAGES_RESET;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_ALLOC;
        req_ch.byte_count    <= '0;
        req_ch.start_address <= '0;
        foreach (link_table[i])
            link_table[i] = 0;
        mem_pages_model = MEM_PAGES_RESET;
        req_idling = 1'b1;
        rsp_idling = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sizes_and_chains();
        test_page_count_limits();
        test_random_traffic();

        wait_drained();
        repeat (32) @(posedge clk);
        $display("checked %0d responses: %0d allocations made, %0d refused",
                 responses_checked, allocs_ok, allocs_failed);
        $display("%0d free requests released %0d pages", frees_done, pages_released);
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb_page_chain_allocator_core: PASS");
        else
        begin
            $display("%0d mismatches, %0d responses never seen",
                     mismatches, due_results.size());
            $display("tb_page_chain_allocator_core: FAIL");
        end
        $finish;
    end

endmodule
